/* src/wbps_pkg.sv */
// Shared constants for the wildcard byte pattern scanner.
package wbps_pkg;

  localparam int BYTE_W       = 8;
  localparam int REG_W        = 64;
  localparam int CFG_INDEX_W  = 3;
  localparam int PATTERN_REGS = 4;
  localparam int CARE_W       = 32;
  localparam int LENGTH_W     = 6;
  localparam int USER_W       = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_0      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_1      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_2      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_3      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CARE_MASK      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd5;

  localparam int USER_WINDOW_RESTART = 0;
  localparam int USER_SCAN_RESTART   = 1;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

/* src/wbps_cell.sv */
// One window cell: holds the byte of a fixed age and tests it against its pattern byte.
module wbps_cell
  import wbps_pkg::*;
#(
  parameter int P     = 32,
  parameter int AGE   = 1,
  parameter int IDX_W = 5,
  parameter int LEN_W = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 restart,
  input  byte_t                byte_in,
  input  logic                 valid_in,
  input  logic [P-1:0][BYTE_W-1:0] pattern,
  input  logic [P-1:0]         care,
  input  logic [LEN_W-1:0]     len,
  output byte_t                byte_out,
  output logic                 valid_out,
  output logic                 ok
);

  byte_t            byte_q;
  logic             valid_q;
  logic             valid_eff;
  logic             in_use;
  logic [LEN_W-1:0] diff;
  logic [IDX_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_q <= byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= valid_in;
    end
  end

  // A section restart drops every byte held before it.
  assign valid_eff = valid_q & ~restart;
  assign in_use    = (len >= LEN_W'(AGE + 1));
  assign diff      = len - LEN_W'(AGE + 1);
  assign idx       = diff[IDX_W-1:0];
  assign ok        = ~in_use | (valid_eff & (~care[idx] | (byte_q == pattern[idx])));
  assign byte_out  = byte_q;
  assign valid_out = valid_eff;

endmodule

/* src/wbps_outq.sv */
// Two-entry output queue: result register plus a skid entry.
module wbps_outq
  import wbps_pkg::*;
#(
  parameter int W = 48
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic         head_valid;
  logic [W-1:0] head_data;
  logic         skid_valid;
  logic [W-1:0] skid_data;
  logic         pop;

  assign pop = head_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!head_valid) begin
        head_valid <= push;
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= push;
        end else begin
          head_valid <= push;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!head_valid || (pop && !skid_valid)) begin
      if (push) begin
        head_data <= push_data;
      end
    end else if (pop) begin
      head_data <= skid_data;
      if (push) begin
        skid_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  assign full      = skid_valid;
  assign out_valid = head_valid;
  assign out_data  = head_data;

endmodule

/* src/wildcard_byte_pattern_scan.sv */
// Top level of the wildcard byte pattern scanner.
//
//   Channel  Direction  Contents
//   s_*      in         tdata: data_byte, byte_address; tuser: window_restart, scan_restart
//   m_*      out        tdata: match_address
//   cfg_*    in         register writes, no read-back
//
// One byte is taken every cycle while the output queue has room; a match request is
// registered in the output queue. The row of window cells compares all held bytes in the cycle the byte is taken.
// Reset clears the held-byte valid bits, the found flag and the output queue.
// The input stalls only while both output queue entries hold undelivered requests.
module wildcard_byte_pattern_scan
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN_BYTES = 32,
  parameter int ADDRESS_BITS      = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // data_byte [7:0], byte_address above it, zero padding to whole bytes
  input  logic [((BYTE_W+ADDRESS_BITS+7)/8)*8-1:0] s_tdata,
  // window_restart [0], scan_restart [1]
  input  logic [USER_W-1:0]         s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // match_address from bit 0, zero padding to whole bytes
  output logic [((ADDRESS_BITS+7)/8)*8-1:0] m_tdata,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [REG_W-1:0]          cfg_data
);

  localparam int P     = MAX_PATTERN_BYTES;
  localparam int A     = ADDRESS_BITS;
  localparam int OUT_W = ((A + 7) / 8) * 8;
  localparam int LEN_W = $clog2(P + 1);
  localparam int IDX_W = (P > 1) ? $clog2(P) : 1;

  logic [PATTERN_REGS-1:0][REG_W-1:0] pattern_bytes;
  logic [CARE_W-1:0]                  care_mask;
  logic [LENGTH_W-1:0]                pattern_length;
  logic                               found;

  logic [PATTERN_REGS*REG_W-1:0]      pattern_flat;
  logic [P-1:0][BYTE_W-1:0]           pattern;
  logic [P-1:0]                       care;
  logic [LENGTH_W-1:0]                len_clip;
  logic [LEN_W-1:0]                   len;
  logic [LEN_W-1:0]                   len_m1;
  logic [IDX_W-1:0]                   idx0;

  byte_t                              data_byte;
  logic [A-1:0]                       byte_address;
  logic                               window_restart;
  logic                               scan_restart;
  logic                               accept;
  logic                               restart;
  logic                               found_eff;
  logic                               match;
  logic [A-1:0]                       match_address;
  logic [P-1:0]                       cell_ok;
  byte_t                              byte_chain [P];
  logic [P-1:0]                       valid_chain;
  logic                               queue_full;
  logic [A-1:0]                       out_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= '0;
      care_mask      <= '1;
      pattern_length <= LENGTH_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_0:      pattern_bytes[0] <= cfg_data;
        REG_PATTERN_1:      pattern_bytes[1] <= cfg_data;
        REG_PATTERN_2:      pattern_bytes[2] <= cfg_data;
        REG_PATTERN_3:      pattern_bytes[3] <= cfg_data;
        REG_CARE_MASK:      care_mask        <= cfg_data[CARE_W-1:0];
        REG_PATTERN_LENGTH: pattern_length   <= cfg_data[LENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign pattern_flat = pattern_bytes;
  assign pattern      = pattern_flat[BYTE_W*P-1:0];
  assign care         = care_mask[P-1:0];

  // Length zero acts as one, lengths past the window act as the full window.
  always_comb begin
    if (pattern_length == '0) begin
      len_clip = LENGTH_W'(1);
    end else if (pattern_length > LENGTH_W'(P)) begin
      len_clip = LENGTH_W'(P);
    end else begin
      len_clip = pattern_length;
    end
  end

  assign len    = len_clip[LEN_W-1:0];
  assign len_m1 = len - LEN_W'(1);
  assign idx0   = len_m1[IDX_W-1:0];

  assign data_byte      = s_tdata[BYTE_W-1:0];
  assign byte_address   = s_tdata[BYTE_W+A-1:BYTE_W];
  assign window_restart = s_tuser[USER_WINDOW_RESTART];
  assign scan_restart   = s_tuser[USER_SCAN_RESTART];
  assign restart        = window_restart | scan_restart;
  assign s_tready       = ~queue_full;
  assign accept         = s_tvalid & s_tready;

  // The byte being taken is always the last byte of the tested window.
  assign byte_chain[0]  = data_byte;
  assign valid_chain[0] = 1'b1;
  assign cell_ok[0]     = ~care[idx0] | (data_byte == pattern[idx0]);

  for (genvar k = 1; k < P; k++) begin : g_cell
    wbps_cell #(
      .P     (P),
      .AGE   (k),
      .IDX_W (IDX_W),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (accept),
      .restart   (restart),
      .byte_in   (byte_chain[k-1]),
      .valid_in  (valid_chain[k-1]),
      .pattern   (pattern),
      .care      (care),
      .len       (len),
      .byte_out  (byte_chain[k]),
      .valid_out (valid_chain[k]),
      .ok        (cell_ok[k])
    );
  end

  assign found_eff     = found & ~scan_restart;
  assign match         = accept & ~found_eff & (&cell_ok);
  assign match_address = byte_address - {{(A-LEN_W){1'b0}}, len_m1};

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept) begin
      found <= found_eff | match;
    end
  end

  wbps_outq #(
    .W (A)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (match),
    .push_data (match_address),
    .full      (queue_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_address)
  );

  assign m_tdata = OUT_W'(out_address);

endmodule

/* src/wbps_checker.sv */
// Port-level checks for the wildcard byte pattern scanner, bound to the top level.
module wbps_checker
  import wbps_pkg::*;
#(
  parameter int ADDRESS_BITS = 48
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [((ADDRESS_BITS+7)/8)*8-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("match request changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output or stall active right after reset");

  a_rose_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("match request without an accepted byte");

  a_stall_needs_pending: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no pending match request");

endmodule

bind wildcard_byte_pattern_scan wbps_checker #(
  .ADDRESS_BITS (ADDRESS_BITS)
) u_wbps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/testbench.sv */
// Self-checking testbench for the wildcard byte pattern scanner with a built-in match predictor.
module testbench;
  import wbps_pkg::*;

  localparam int ADDR_W       = 48;
  localparam int MAX_LEN      = 32;
  localparam int S_DATA_W     = ((BYTE_W + ADDR_W + 7) / 8) * 8;
  localparam int M_DATA_W     = ((ADDR_W + 7) / 8) * 8;
  localparam int RANDOM_BYTES = 1550;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_SHOWN    = 10;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    byte_t data;
    addr_t addr;
    logic  win_restart;
    logic  scan_restart;
  } byte_req_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_DATA_W-1:0]    s_tdata   = '0;
  logic [USER_W-1:0]      s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_DATA_W-1:0]    m_tdata;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]       cfg_data  = '0;

  // Predictor copy of the registers and the scan state.
  logic [REG_W-1:0]    pattern_reg [PATTERN_REGS];
  logic [CARE_W-1:0]   care_reg   = '1;
  logic [LENGTH_W-1:0] length_reg = 6'd1;
  byte_t               recent [MAX_LEN-1];
  int                  held  = 0;
  bit                  found = 1'b0;

  addr_t     expected_matches [$];
  byte_req_t pending_bytes [$];

  byte_req_t         current_req;
  byte_req_t         next_req;
  logic [USER_W-1:0] next_user;
  int                tx_gap = 0;
  bit                tx_steady = 1'b0;
  int                rx_wait = 0;
  int                rx_stall;
  bit                rx_steady = 1'b0;
  addr_t             want;

  int queued = 0;
  int bytes_sent = 0;
  int matches_seen = 0;
  int settings_used = 0;
  int errors = 0;
  int cycles = 0;

  wildcard_byte_pattern_scan #(
    .MAX_PATTERN_BYTES(MAX_LEN),
    .ADDRESS_BITS(ADDR_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int active_len();
    if (length_reg == 0) return 1;
    if (length_reg > MAX_LEN) return MAX_LEN;
    return int'(length_reg);
  endfunction

  function automatic byte_t pattern_at(int j);
    return pattern_reg[j / 8][8 * (j % 8) +: 8];
  endfunction

  // Restarts apply first, then the window ending in this byte is compared.
  function automatic void predict_scan(byte_req_t req);
    int    len;
    bit    hit;
    byte_t w;
    len = active_len();
    if (req.scan_restart) begin
      found = 1'b0;
      held = 0;
    end
    if (req.win_restart) held = 0;
    if (!found && held + 1 >= len) begin
      hit = 1'b1;
      for (int i = 0; i < len; i++) begin
        w = (i == len - 1) ? req.data : recent[len - 2 - i];
        if (care_reg[i] && w != pattern_at(i)) hit = 1'b0;
      end
      if (hit) begin
        found = 1'b1;
        expected_matches.insert(expected_matches.size(), req.addr - addr_t'(len - 1));
      end
    end
    for (int i = MAX_LEN - 2; i > 0; i--) recent[i] = recent[i - 1];
    recent[0] = req.data;
    if (held < MAX_LEN - 1) held++;
  endfunction

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("mismatch: %s", msg);
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_scan(current_req);
        bytes_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap != 0) begin
          s_tvalid <= 1'b0;
          tx_gap <= tx_gap - 1;
        end else if (pending_bytes.size() != 0) begin
          next_req = pending_bytes.pop_front();
          next_user = '0;
          next_user[USER_WINDOW_RESTART] = next_req.win_restart;
          next_user[USER_SCAN_RESTART] = next_req.scan_restart;
          if ($urandom_range(0, 15) == 0) tx_steady = !tx_steady;
          s_tvalid <= 1'b1;
          s_tdata <= S_DATA_W'({next_req.addr, next_req.data});
          s_tuser <= next_user;
          current_req <= next_req;
          tx_gap <= tx_steady ? 0 : $urandom_range(0, 6);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Match monitor.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      matches_seen++;
      if (expected_matches.size() == 0) begin
        note_failure($sformatf("unexpected match address %h", m_tdata));
      end else begin
        want = expected_matches.pop_front();
        if (m_tdata !== M_DATA_W'(want))
          note_failure($sformatf("match address expected %h, got %h", want, m_tdata));
      end
      if ($urandom_range(0, 15) == 0) rx_steady = !rx_steady;
      rx_stall = rx_steady ? 0 : $urandom_range(0, 6);
      rx_wait <= rx_stall;
      m_tready <= (rx_stall == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      m_tready <= (rx_wait == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic queue_byte(input byte_t data, input addr_t addr, input bit win, input bit scan);
    byte_req_t req;
    req.data = data;
    req.addr = addr;
    req.win_restart = win;
    req.scan_restart = scan;
    pending_bytes.insert(pending_bytes.size(), req);
    queued++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_CARE_MASK: care_reg = val[CARE_W-1:0];
      REG_PATTERN_LENGTH: length_reg = val[LENGTH_W-1:0];
      default: pattern_reg[idx] = val;
    endcase
  endtask

  task automatic load_config(input logic [REG_W-1:0] p0, p1, p2, p3, care, len);
    write_reg(REG_PATTERN_0, p0);
    write_reg(REG_PATTERN_1, p1);
    write_reg(REG_PATTERN_2, p2);
    write_reg(REG_PATTERN_3, p3);
    write_reg(REG_CARE_MASK, care);
    write_reg(REG_PATTERN_LENGTH, len);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // The scanner is idle once no request is pending and no match is owed.
  task automatic wait_idle();
    bit busy;
    busy = 1'b1;
    while (busy) begin
      @(negedge clk);
      while (pending_bytes.size() != 0 || s_tvalid || expected_matches.size() != 0)
        @(negedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
      @(negedge clk);
      busy = pending_bytes.size() != 0 || s_tvalid || expected_matches.size() != 0;
    end
  endtask

  function automatic addr_t pick_base();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return addr_t'(0) - addr_t'($urandom_range(1, 40));
      default: return addr_t'({$urandom, $urandom});
    endcase
  endfunction

  // A section of consecutive addresses, usually with the pattern planted somewhere in it.
  task automatic queue_section(input int n, input bit new_scan);
    addr_t base;
    int    len;
    int    at;
    bit    plant;
    bit    scan_bit;
    byte_t b;
    len = active_len();
    base = pick_base();
    plant = $urandom_range(0, 3) != 0;
    at = $urandom_range(0, n - 1);
    for (int j = 0; j < n; j++) begin
      if (plant && j >= at && j < at + len && care_reg[j - at])
        b = pattern_at(j - at);
      else if ($urandom_range(0, 1) == 0)
        b = pattern_at($urandom_range(0, len - 1));
      else
        b = byte_t'($urandom);
      scan_bit = (j == 0) ? new_scan : ($urandom_range(0, 79) == 0);
      queue_byte(b, base + addr_t'(j), j == 0, scan_bit);
    end
  endtask

  initial begin
    logic [REG_W-1:0] pat [PATTERN_REGS];
    logic [REG_W-1:0] care_word;
    logic [REG_W-1:0] len_word;
    int               phase;
    int               phase_end;
    int               directed_count;
    for (int i = 0; i < PATTERN_REGS; i++) pattern_reg[i] = '0;
    for (int i = 0; i < MAX_LEN - 1; i++) recent[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one byte of 0x00; found holds across a section restart.
    queue_byte(8'hFF, '1, 1'b1, 1'b1);
    queue_byte(8'h00, '0, 1'b1, 1'b0);
    queue_byte(8'h00, 48'd1, 1'b0, 1'b0);
    queue_byte(8'h00, 48'd2, 1'b1, 1'b0);
    queue_byte(8'h00, '1, 1'b0, 1'b1);
    queue_byte(8'h80, 48'd3, 1'b0, 1'b0);
    wait_idle();

    // A length of zero behaves as a single byte.
    load_config(64'h0000_0000_0000_00FF, '1, '1, '1, '1, 64'd0);
    queue_byte(8'hFF, 48'd7, 1'b1, 1'b1);
    queue_byte(8'hFE, 48'd8, 1'b0, 1'b1);
    wait_idle();

    // Three bytes with a wildcard in the middle: short section, match, address wrap.
    load_config(64'hFFFF_FFFF_FF33_2211, '0, '0, '0, 64'hFFFF_FFFD, 64'd3);
    queue_byte(8'h11, 48'd100, 1'b1, 1'b1);
    queue_byte(8'h77, 48'd101, 1'b0, 1'b0);
    queue_byte(8'h33, 48'd102, 1'b1, 1'b0);
    queue_byte(8'h11, 48'd200, 1'b1, 1'b0);
    queue_byte(8'h99, 48'd201, 1'b0, 1'b0);
    queue_byte(8'h33, 48'd202, 1'b0, 1'b0);
    queue_byte(8'h11, '1, 1'b1, 1'b1);
    queue_byte(8'hAB, '0, 1'b0, 1'b0);
    queue_byte(8'h33, 48'd1, 1'b0, 1'b0);
    wait_idle();
    directed_count = queued;

    phase = 0;
    while (queued < directed_count + RANDOM_BYTES) begin
      for (int r = 0; r < PATTERN_REGS; r++) begin
        case ($urandom_range(0, 5))
          0: pat[r] = '0;
          1: pat[r] = '1;
          default: pat[r] = {$urandom, $urandom};
        endcase
      end
      care_word = {$urandom, $urandom};
      len_word = {$urandom, $urandom};
      case (phase)
        0: begin
          care_word[CARE_W-1:0] = '1;
          len_word[LENGTH_W-1:0] = 6'd32;
        end
        1: len_word[LENGTH_W-1:0] = 6'd40;
        2: begin
          care_word[CARE_W-1:0] = '0;
          len_word[LENGTH_W-1:0] = 6'd63;
        end
        3: begin
          care_word[CARE_W-1:0] = '0;
          len_word[LENGTH_W-1:0] = 6'd1;
        end
        4: len_word[LENGTH_W-1:0] = 6'd0;
        default: begin
          if ($urandom_range(0, 3) == 0)
            len_word[LENGTH_W-1:0] = LENGTH_W'($urandom_range(1, 32));
          else
            len_word[LENGTH_W-1:0] = LENGTH_W'($urandom_range(1, 8));
          case ($urandom_range(0, 2))
            0: care_word[CARE_W-1:0] = '1;
            1: care_word[CARE_W-1:0] = ~(32'd1 << $urandom_range(0, 31));
            default: ;
          endcase
        end
      endcase
      load_config(pat[0], pat[1], pat[2], pat[3], care_word, len_word);
      phase_end = queued + 60 + $urandom_range(0, 80);
      while (queued < phase_end)
        queue_section($urandom_range(1, active_len() + 24), $urandom_range(0, 1));
      wait_idle();
      phase++;
    end

    $display("Scanned %0d bytes (%0d directed) under %0d register settings.",
             bytes_sent, directed_count, settings_used + 1);
    $display("Checked %0d match reports; %0d mismatches.", matches_seen, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
